/* rtl/gasr_pkg.sv */
package gasr_pkg;

	localparam int MAX_REF_LEN = 256;
	localparam int SYM_W       = 8;
	localparam int LEN_W       = $clog2(MAX_REF_LEN + 1);
	localparam int IDX_W       = $clog2(MAX_REF_LEN);
	localparam int SCORE_W     = 24;
	localparam int ROW_W       = 16;
	localparam int CFG_W       = 7;
	// room for a saturated score plus a 7-bit term, or the widest edge formula
	localparam int SC_W        = 26;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] REG_MATCH    = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP      = 2'd2;

	localparam logic [ROW_W-1:0] ROW_MAX = {ROW_W{1'b1}};

	localparam logic signed [SC_W-1:0] SAT_HI = SC_W'(8388607);
	localparam logic signed [SC_W-1:0] SAT_LO = -SC_W'(8388608);

	typedef struct packed {
		logic signed [CFG_W-1:0] match;
		logic signed [CFG_W-1:0] mismatch;
		logic signed [CFG_W-1:0] gap;
	} scores_t;

	// one query row travelling along the cells
	typedef struct packed {
		logic                      valid;
		logic                      done;
		logic                      empty;
		logic [SYM_W-1:0]          sym;
		logic [ROW_W-1:0]          row;
		logic [IDX_W-1:0]          remaining;
		logic signed [SCORE_W-1:0] left;
		logic signed [SCORE_W-1:0] diag;
	} token_t;

	function automatic logic signed [SCORE_W-1:0] sat_score(input logic signed [SC_W-1:0] v);
		logic signed [SCORE_W-1:0] r;
		if (v > SAT_HI) begin
			r = SAT_HI[SCORE_W-1:0];
		end else if (v < SAT_LO) begin
			r = SAT_LO[SCORE_W-1:0];
		end else begin
			r = v[SCORE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* rtl/gasr_if.sv */
interface gasr_in_if import gasr_pkg::*;;
	logic             valid;
	logic             ready;
	logic [1:0]       operation;
	logic [SYM_W-1:0] symbol;
	logic             end_of_query;

	modport source(output valid, output operation, output symbol, output end_of_query,
		input ready);
	modport sink(input valid, input operation, input symbol, input end_of_query,
		output ready);
endinterface

interface gasr_out_if import gasr_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] row_score;
	logic [ROW_W-1:0]          row_number;
	logic                      empty_reference;

	modport source(output valid, output row_score, output row_number,
		output empty_reference, input ready);
	modport sink(input valid, input row_score, input row_number,
		input empty_reference, output ready);
endinterface

/* rtl/gasr_cell.sv */
module gasr_cell import gasr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  logic             wr_en,
	input  logic [SYM_W-1:0] wr_sym,
	input  scores_t          scores,
	input  token_t           tin,
	output token_t           tout
);

	logic [SYM_W-1:0]          sym_q;
	logic signed [SCORE_W-1:0] above_q;
	token_t                    tout_q;
	token_t                    tnext;

	logic signed [SC_W-1:0] s_x, gap_x, diag_c, left_c, up_c, best, edge_row, edge_col;
	logic signed [SC_W-1:0] v_raw;
	logic signed [SCORE_W-1:0] v;

	always_comb begin
		s_x    = (sym_q == tin.sym) ? SC_W'(scores.match) : SC_W'(scores.mismatch);
		gap_x  = SC_W'(scores.gap);
		diag_c = SC_W'(tin.diag) + s_x;
		left_c = SC_W'(tin.left) + gap_x;
		up_c   = SC_W'(above_q) + gap_x;
		best   = (diag_c > left_c) ? diag_c : left_c;
		if (up_c > best) begin
			best = up_c;
		end
		// first column and first row edges: s + 2 - 2 * index
		edge_row = s_x + SC_W'(2)
			- $signed({{(SC_W-ROW_W-1){1'b0}}, tin.row, 1'b0});
		edge_col = s_x + SC_W'(2)
			- $signed({{(SC_W-IDX_W-1){1'b0}}, idx, 1'b0});
		if (tin.row == '0 && idx == '0) begin
			v_raw = '0;
		end else if (idx == '0) begin
			v_raw = edge_row;
		end else if (tin.row == '0) begin
			v_raw = edge_col;
		end else begin
			v_raw = best;
		end
		v = sat_score(v_raw);

		tnext = tin;
		if (tin.valid && !tin.done) begin
			tnext.left      = v;
			tnext.diag      = above_q;
			tnext.done      = (tin.remaining == '0);
			tnext.remaining = tin.remaining - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_q <= wr_sym;
		end
		if (en && tin.valid && !tin.done) begin
			above_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_q <= '0;
		end else if (en) begin
			tout_q <= tnext;
		end
	end

	assign tout = tout_q;

endmodule

/* rtl/global_alignment_score_rows.sv */
// Global alignment score engine with a linear gap penalty. Reference symbols are
// appended one per transaction into a row of MAX_REF_LEN cells; each cell keeps its
// symbol and its column of the previous score row. A query symbol enters the row as
// a token that computes one cell per cycle while the row advances and passes through
// all MAX_REF_LEN cells before its result is registered, whatever the reference
// length. A new transaction of any operation is taken every cycle; the whole row
// stalls only while a finished result waits in the output register. An operation
// of 3 is dropped without a result.
module global_alignment_score_rows import gasr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	gasr_in_if.sink          query,
	gasr_out_if.source       result
);

	scores_t          scores_q;
	logic [LEN_W-1:0] ref_len_q;
	logic [ROW_W-1:0] row_q;

	logic                      out_valid_q;
	logic signed [SCORE_W-1:0] out_score_q;
	logic [ROW_W-1:0]          out_row_q;
	logic                      out_empty_q;

	logic   advance, acc, append_wr;
	token_t chain [MAX_REF_LEN+1];
	logic   [MAX_REF_LEN-1:0] wr_en;

	assign advance     = !out_valid_q || result.ready;
	assign query.ready = advance;
	assign acc         = query.valid && advance;
	assign append_wr   = acc && query.operation == OP_APPEND
		&& ref_len_q < LEN_W'(MAX_REF_LEN);

	always_comb begin
		chain[0]           = '0;
		chain[0].valid     = acc && query.operation == OP_QUERY;
		chain[0].done      = (ref_len_q == '0);
		chain[0].empty     = (ref_len_q == '0);
		chain[0].sym       = query.symbol;
		chain[0].row       = row_q;
		chain[0].remaining = ref_len_q[IDX_W-1:0] - 1'b1;
	end

	for (genvar i = 0; i < MAX_REF_LEN; i++) begin : g_cell
		assign wr_en[i] = append_wr && ref_len_q == LEN_W'(i);
		gasr_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (advance),
			.idx    (IDX_W'(i)),
			.wr_en  (wr_en[i]),
			.wr_sym (query.symbol),
			.scores (scores_q),
			.tin    (chain[i]),
			.tout   (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scores_q <= '{match: CFG_W'(1), mismatch: -CFG_W'(1), gap: -CFG_W'(2)};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MATCH:    scores_q.match    <= cfg_data;
				REG_MISMATCH: scores_q.mismatch <= cfg_data;
				REG_GAP:      scores_q.gap      <= cfg_data;
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_len_q <= '0;
			row_q     <= '0;
		end else if (acc) begin
			case (query.operation)
				OP_CLEAR: begin
					ref_len_q <= '0;
					row_q     <= '0;
				end
				OP_APPEND: begin
					if (ref_len_q < LEN_W'(MAX_REF_LEN)) begin
						ref_len_q <= ref_len_q + 1'b1;
					end
					row_q <= '0;
				end
				OP_QUERY: begin
					if (query.end_of_query) begin
						row_q <= '0;
					end else if (row_q != ROW_MAX) begin
						row_q <= row_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= chain[MAX_REF_LEN].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			// an empty reference token never touched a cell and still carries zero
			out_score_q <= chain[MAX_REF_LEN].left;
			out_row_q   <= chain[MAX_REF_LEN].row;
			out_empty_q <= chain[MAX_REF_LEN].empty;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.row_score       = out_score_q;
	assign result.row_number      = out_row_q;
	assign result.empty_reference = out_empty_q;

endmodule

/* rtl/gasr_checker.sv */
module gasr_checker import gasr_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      q_ready,
	input logic                      r_valid,
	input logic                      r_ready,
	input logic signed [SCORE_W-1:0] r_score,
	input logic [ROW_W-1:0]          r_row,
	input logic                      r_empty
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> $stable(r_score) && $stable(r_row) && $stable(r_empty))
		else $error("result payload changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && r_empty |-> r_score == '0)
		else $error("empty reference with nonzero score");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid || r_ready |-> q_ready)
		else $error("input stalled with output free");

endmodule

bind global_alignment_score_rows gasr_checker u_gasr_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.q_ready (query.ready),
	.r_valid (result.valid),
	.r_ready (result.ready),
	.r_score (result.row_score),
	.r_row   (result.row_number),
	.r_empty (result.empty_reference)
);
